// File: sv/bba_pkg.sv
// Shared codes and defaults for the buddy block allocator.
package bba_pkg;

  localparam int unsigned MaxOrderDef    = 12;
  localparam int unsigned MinOrderDef    = 5;
  localparam int unsigned MaxPagesDef    = 16;
  localparam int unsigned HeaderBytesDef = 24;

  localparam int unsigned PagesReset = 16;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_ZERO_SIZE = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  typedef enum logic {
    REG_POOL_BASE    = 1'b0,
    REG_PAGES_IN_USE = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_SPLIT,
    S_FREE_CHK,
    S_MERGE_RD,
    S_MERGE_CHK,
    S_FINAL,
    S_DONE
  } fsm_t;

endpackage

// File: sv/bba_mem.sv
// Slot table memory: one write port, one read port, registered read data.
module bba_mem #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11,
  parameter int unsigned DW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/bba_ctrl.sv
// Allocator sequencer: clear pass, free-block scan, split and merge walks.
module bba_ctrl #(
  parameter int unsigned PAGE_ORDER   = bba_pkg::MaxOrderDef,
  parameter int unsigned MIN_ORDER    = bba_pkg::MinOrderDef,
  parameter int unsigned MAX_PAGES    = bba_pkg::MaxPagesDef,
  parameter int unsigned HEADER_BYTES = bba_pkg::HeaderBytesDef,
  parameter int unsigned TOP          = PAGE_ORDER - MIN_ORDER,
  parameter int unsigned LVL_W        = $clog2(TOP + 1),
  parameter int unsigned SLOT_W       = $clog2(MAX_PAGES << TOP) > 0 ?
                                        $clog2(MAX_PAGES << TOP) : 1,
  parameter int unsigned EW           = LVL_W + 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              operation,
  input  logic [15:0]       request_size,
  input  logic [31:0]       free_address,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       result_address,
  output logic [1:0]        status,
  output logic              wr_en,
  output logic [SLOT_W-1:0] wr_addr,
  output logic [EW-1:0]     wr_data,
  output logic              rd_en,
  output logic [SLOT_W-1:0] rd_addr,
  input  logic [EW-1:0]     rd_data
);

  localparam int unsigned TOTAL = MAX_PAGES << TOP;
  localparam int unsigned CW    = SLOT_W + 1;
  localparam int unsigned NW    = (PAGE_ORDER + 2 > 17) ? PAGE_ORDER + 2 : 17;
  localparam int unsigned HW    = 32 - MIN_ORDER;

  bba_pkg::fsm_t state, state_next;

  logic [CW-1:0]     cnt, cnt_next;
  logic              pend, pend_next;
  logic              found, found_next;
  logic [SLOT_W-1:0] best, best_next;
  logic [LVL_W-1:0]  best_lvl, best_lvl_next;
  logic [LVL_W-1:0]  lvl, lvl_next;
  logic [SLOT_W-1:0] cur_s, cur_s_next;
  logic [LVL_W-1:0]  cur_o, cur_o_next;
  logic [SLOT_W-1:0] bud, bud_next;
  logic [31:0]       res_addr, res_addr_next;
  logic [1:0]        res_st, res_st_next;
  logic              out_valid_next;
  logic [31:0]       result_address_next;
  logic [1:0]        status_next;
  logic [31:0]       pool_base;
  logic [CW-1:0]     used, used_next;

  logic [NW-1:0]     need;
  logic [LVL_W-1:0]  req_lvl;
  logic [31:0]       off;
  logic [HW-1:0]     off_slot;
  logic              bad_free;
  logic              d_head, d_free;
  logic [LVL_W-1:0]  d_ord;
  logic [8:0]        pages_cl;

  assign d_head = rd_data[EW-1];
  assign d_free = rd_data[EW-2];
  assign d_ord  = rd_data[LVL_W-1:0];

  assign need = NW'(request_size) + NW'(HEADER_BYTES);
  assign off  = free_address - 32'(HEADER_BYTES) - pool_base;
  assign off_slot = off[31:MIN_ORDER];
  assign bad_free = (free_address == 32'd0) || (|off[MIN_ORDER-1:0]) ||
                    (off_slot >= HW'(used));

  always_comb begin
    req_lvl = '0;
    for (int l = 0; l < int'(TOP); l++) begin
      if ((NW'(1) << (l + int'(MIN_ORDER))) < need) begin
        req_lvl = req_lvl + LVL_W'(1);
      end
    end
  end

  always_comb begin
    pages_cl = (9'(cfg_data[4:0]) > 9'(MAX_PAGES)) ? 9'(MAX_PAGES) : 9'(cfg_data[4:0]);
    used_next = used;
    if (cfg_we && cfg_index == bba_pkg::REG_PAGES_IN_USE) begin
      used_next = CW'(32'(pages_cl) << TOP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bba_pkg::S_CLEAR;
      cnt       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
      pool_base <= '0;
      used      <= CW'((MAX_PAGES < bba_pkg::PagesReset ? MAX_PAGES : bba_pkg::PagesReset) << TOP);
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
      used      <= used_next;
      if (cfg_we && cfg_index == bba_pkg::REG_POOL_BASE) begin
        pool_base <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    found          <= found_next;
    best           <= best_next;
    best_lvl       <= best_lvl_next;
    lvl            <= lvl_next;
    cur_s          <= cur_s_next;
    cur_o          <= cur_o_next;
    bud            <= bud_next;
    res_addr       <= res_addr_next;
    res_st         <= res_st_next;
    result_address <= result_address_next;
    status         <= status_next;
  end

  always_comb begin
    state_next          = state;
    cnt_next            = cnt;
    pend_next           = 1'b0;
    found_next          = found;
    best_next           = best;
    best_lvl_next       = best_lvl;
    lvl_next            = lvl;
    cur_s_next          = cur_s;
    cur_o_next          = cur_o;
    bud_next            = bud;
    res_addr_next       = res_addr;
    res_st_next         = res_st;
    result_address_next = result_address;
    status_next         = status;
    out_valid_next      = out_valid && out_stall;
    in_stall            = (state != bba_pkg::S_IDLE);
    wr_en               = 1'b0;
    wr_addr             = cur_s;
    wr_data             = '0;
    rd_en               = 1'b0;
    rd_addr             = cur_s;

    case (state)
      bba_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt[SLOT_W-1:0];
        if (cnt < used && cnt[TOP-1:0] == '0) begin
          wr_data = {1'b1, 1'b1, LVL_W'(TOP)};
        end
        cnt_next = cnt + CW'(1);
        if (cnt == CW'(TOTAL - 1)) begin
          state_next = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_IDLE: begin
        if (in_valid) begin
          res_addr_next = '0;
          if (operation == bba_pkg::OP_ALLOC) begin
            lvl_next   = req_lvl;
            cnt_next   = '0;
            found_next = 1'b0;
            if (request_size == 16'd0) begin
              res_st_next = bba_pkg::ST_ZERO_SIZE;
              state_next  = bba_pkg::S_DONE;
            end else if (need > (NW'(1) << PAGE_ORDER)) begin
              res_st_next = bba_pkg::ST_NO_SPACE;
              state_next  = bba_pkg::S_DONE;
            end else begin
              state_next = bba_pkg::S_SCAN;
            end
          end else begin
            cur_s_next  = off_slot[SLOT_W-1:0];
            rd_addr     = off_slot[SLOT_W-1:0];
            rd_en       = !bad_free;
            res_st_next = bba_pkg::ST_BAD_FREE;
            state_next  = bad_free ? bba_pkg::S_DONE : bba_pkg::S_FREE_CHK;
          end
        end
      end
      bba_pkg::S_SCAN: begin
        // issue one slot read per cycle, judge the slot read the cycle before
        if (pend && d_head && d_free && d_ord >= lvl && d_ord == lvl) begin
          best_next  = cnt[SLOT_W-1:0] - SLOT_W'(1);
          cur_o_next = lvl;
          state_next = bba_pkg::S_SPLIT;
        end else begin
          if (pend && d_head && d_free && d_ord >= lvl && (!found || d_ord < best_lvl)) begin
            found_next    = 1'b1;
            best_next     = cnt[SLOT_W-1:0] - SLOT_W'(1);
            best_lvl_next = d_ord;
          end
          if (cnt < used) begin
            rd_en     = 1'b1;
            rd_addr   = cnt[SLOT_W-1:0];
            pend_next = 1'b1;
            cnt_next  = cnt + CW'(1);
          end else if (!pend) begin
            if (found) begin
              cur_o_next = best_lvl;
              state_next = bba_pkg::S_SPLIT;
            end else begin
              res_st_next = bba_pkg::ST_NO_SPACE;
              state_next  = bba_pkg::S_DONE;
            end
          end
        end
      end
      bba_pkg::S_SPLIT: begin
        wr_en = 1'b1;
        if (cur_o > lvl) begin
          wr_addr    = best + (SLOT_W'(1) << (cur_o - LVL_W'(1)));
          wr_data    = {1'b1, 1'b1, cur_o - LVL_W'(1)};
          cur_o_next = cur_o - LVL_W'(1);
        end else begin
          wr_addr       = best;
          wr_data       = {1'b1, 1'b0, lvl};
          res_addr_next = pool_base + (32'(best) << MIN_ORDER) + 32'(HEADER_BYTES);
          res_st_next   = bba_pkg::ST_OK;
          state_next    = bba_pkg::S_DONE;
        end
      end
      bba_pkg::S_FREE_CHK: begin
        if (d_head && !d_free) begin
          cur_o_next = d_ord;
          state_next = bba_pkg::S_MERGE_RD;
        end else begin
          state_next = bba_pkg::S_DONE;
        end
      end
      bba_pkg::S_MERGE_RD: begin
        bud_next = cur_s ^ (SLOT_W'(1) << cur_o);
        rd_addr  = cur_s ^ (SLOT_W'(1) << cur_o);
        if (cur_o < LVL_W'(TOP) && CW'(cur_s ^ (SLOT_W'(1) << cur_o)) < used) begin
          rd_en      = 1'b1;
          state_next = bba_pkg::S_MERGE_CHK;
        end else begin
          state_next = bba_pkg::S_FINAL;
        end
      end
      bba_pkg::S_MERGE_CHK: begin
        if (d_head && d_free && d_ord == cur_o) begin
          // absorb the buddy: clear the upper head, keep the lower one
          wr_en      = 1'b1;
          wr_addr    = (cur_s < bud) ? bud : cur_s;
          cur_s_next = (cur_s < bud) ? cur_s : bud;
          cur_o_next = cur_o + LVL_W'(1);
          state_next = bba_pkg::S_MERGE_RD;
        end else begin
          state_next = bba_pkg::S_FINAL;
        end
      end
      bba_pkg::S_FINAL: begin
        wr_en       = 1'b1;
        wr_addr     = cur_s;
        wr_data     = {1'b1, 1'b1, cur_o};
        res_st_next = bba_pkg::ST_OK;
        state_next  = bba_pkg::S_DONE;
      end
      bba_pkg::S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next      = 1'b1;
          result_address_next = res_addr;
          status_next         = res_st;
          state_next          = bba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bba_pkg::S_IDLE;
      end
    endcase

    // a page count write rebuilds the whole pool
    if (cfg_we && cfg_index == bba_pkg::REG_PAGES_IN_USE) begin
      state_next = bba_pkg::S_CLEAR;
      cnt_next   = '0;
    end
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == bba_pkg::S_IDLE |-> !wr_en)
    else $error("slot table written while idle");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == bba_pkg::S_DONE)
    else $error("result raised outside completion");

  a_split_range: assert property (@(posedge clk) disable iff (rst)
    state == bba_pkg::S_SPLIT |-> cur_o >= lvl)
    else $error("split walked below requested order");

  a_merge_top: assert property (@(posedge clk) disable iff (rst)
    state == bba_pkg::S_MERGE_CHK |-> cur_o < LVL_W'(TOP))
    else $error("merge past page order");

endmodule

// File: sv/buddy_block_allocator.sv
// Buddy block allocator top level: slot table memory and its sequencer.
//
//  channel | signals                                          | direction
//  in      | in_valid, in_stall, operation, request_size,     | item in
//          | free_address                                     |
//  out     | out_valid, out_stall, result_address, status     | result out
//  cfg     | cfg_we, cfg_index, cfg_data                      | register write
//
// An allocate scans the used slots, then splits the block down level by level: the scan
// reads one slot per cycle from the single read port and ends early on a block
// of the exact order. A zero-size or oversize allocate skips the scan.
// A valid free merges free buddies up to the page order; a rejected one skips the merge walk.
// After reset and after each pages_in_use write a clearing pass over all
// MAX_PAGES << (PAGE_ORDER-MIN_ORDER) slots holds in_stall high.
// A stalled result is held in the output register while the next item enters.
module buddy_block_allocator #(
  parameter int unsigned PAGE_ORDER   = bba_pkg::MaxOrderDef,
  parameter int unsigned MIN_ORDER    = bba_pkg::MinOrderDef,
  parameter int unsigned MAX_PAGES    = bba_pkg::MaxPagesDef,
  parameter int unsigned HEADER_BYTES = bba_pkg::HeaderBytesDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [15:0] request_size,
  input  logic [31:0] free_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_address,
  output logic [1:0]  status
);

  localparam int unsigned TOP    = PAGE_ORDER - MIN_ORDER;
  localparam int unsigned LVL_W  = $clog2(TOP + 1);
  localparam int unsigned TOTAL  = MAX_PAGES << TOP;
  localparam int unsigned SLOT_W = $clog2(TOTAL) > 0 ? $clog2(TOTAL) : 1;
  localparam int unsigned EW     = LVL_W + 2;

  logic              wr_en, rd_en;
  logic [SLOT_W-1:0] wr_addr, rd_addr;
  logic [EW-1:0]     wr_data, rd_data;

  bba_ctrl #(
    .PAGE_ORDER(PAGE_ORDER), .MIN_ORDER(MIN_ORDER), .MAX_PAGES(MAX_PAGES),
    .HEADER_BYTES(HEADER_BYTES), .TOP(TOP), .LVL_W(LVL_W), .SLOT_W(SLOT_W),
    .EW(EW)
  ) u_ctrl (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .request_size(request_size),
    .free_address(free_address), .out_valid(out_valid), .out_stall(out_stall),
    .result_address(result_address), .status(status), .wr_en(wr_en),
    .wr_addr(wr_addr), .wr_data(wr_data), .rd_en(rd_en), .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  bba_mem #(.DEPTH(TOTAL), .AW(SLOT_W), .DW(EW)) u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
  );

endmodule

// File: tb/buddy_block_allocator_tb.sv
// Testbench for the buddy block allocator: queued stimulus, clocked driver and monitor.
module buddy_block_allocator_tb;

  localparam int unsigned MaxOrder  = bba_pkg::MaxOrderDef;
  localparam int unsigned MinOrder  = bba_pkg::MinOrderDef;
  localparam int unsigned NumPages  = bba_pkg::MaxPagesDef;
  localparam int unsigned HdrBytes  = bba_pkg::HeaderBytesDef;
  localparam int unsigned PageSlots = 1 << (MaxOrder - MinOrder);
  localparam int unsigned NumSlots  = NumPages * PageSlots;
  localparam int unsigned TopLevel  = MaxOrder - MinOrder;
  localparam longint      CycleCap  = 12000000;

  typedef struct packed {
    bba_pkg::op_t op;
    logic [15:0]  size;
    logic [31:0]  addr;
  } req_t;

  typedef struct packed {
    logic [31:0]      addr;
    bba_pkg::status_t st;
  } rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = 1'b0;
  logic [15:0] request_size = '0;
  logic [31:0] free_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] result_address;
  logic [1:0]  status;

  buddy_block_allocator i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // allocator shadow state
  logic [31:0] base_q;
  int unsigned pages_q;
  bit          sl_free [NumSlots];
  bit          sl_head [NumSlots];
  int unsigned sl_order [NumSlots];
  logic [31:0] live_addrs [$];

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  int   errors = 0;
  int   n_sent = 0, n_seen = 0, n_ok_alloc = 0, n_ok_free = 0;
  longint cycles = 0;

  function automatic int unsigned live_slots();
    return ((pages_q > NumPages) ? NumPages : pages_q) * PageSlots;
  endfunction

  function automatic void reset_pool();
    for (int s = 0; s < NumSlots; s++) begin
      sl_free[s] = 0; sl_head[s] = 0; sl_order[s] = 0;
    end
    for (int s = 0; s < live_slots(); s += PageSlots) begin
      sl_free[s] = 1; sl_head[s] = 1; sl_order[s] = TopLevel;
    end
  endfunction

  function automatic rsp_t allocate_block(logic [15:0] size);
    rsp_t r;
    int unsigned need, lvl, best, best_lvl, i;
    bit found;
    r.addr = '0;
    need = size + HdrBytes;
    lvl = 0; found = 0; best = 0; best_lvl = 0;
    if (size == 0) begin
      r.st = bba_pkg::ST_ZERO_SIZE;
      return r;
    end
    if (need > (1 << MaxOrder)) begin
      r.st = bba_pkg::ST_NO_SPACE;
      return r;
    end
    while ((1 << (lvl + MinOrder)) < need) lvl++;
    for (int s = 0; s < live_slots(); s++) begin
      if (sl_head[s] && sl_free[s] && sl_order[s] >= lvl && (!found || sl_order[s] < best_lvl)) begin
        found = 1; best = s; best_lvl = sl_order[s];
      end
    end
    if (!found) begin
      r.st = bba_pkg::ST_NO_SPACE;
      return r;
    end
    i = best_lvl;
    while (i > lvl) begin
      i--;
      sl_head[best + (1 << i)] = 1;
      sl_free[best + (1 << i)] = 1;
      sl_order[best + (1 << i)] = i;
    end
    sl_free[best] = 0;
    sl_order[best] = lvl;
    r.addr = base_q + (best << MinOrder) + HdrBytes;
    r.st = bba_pkg::ST_OK;
    return r;
  endfunction

  function automatic rsp_t release_block(logic [31:0] addr);
    rsp_t r;
    logic [31:0] off;
    int unsigned s, o, b, lo;
    r.addr = '0;
    r.st = bba_pkg::ST_BAD_FREE;
    if (addr == 0) return r;
    off = addr - HdrBytes - base_q;
    if (off[MinOrder-1:0] != 0) return r;
    if ((off >> MinOrder) >= live_slots()) return r;
    s = off >> MinOrder;
    if (!sl_head[s] || sl_free[s]) return r;
    o = sl_order[s];
    while (o < TopLevel) begin
      b = s ^ (1 << o);
      if (b >= live_slots() || !sl_head[b] || !sl_free[b] || sl_order[b] != o) break;
      lo = (s < b) ? s : b;
      sl_head[s + b - lo] = 0; sl_free[s + b - lo] = 0; sl_order[s + b - lo] = 0;
      s = lo;
      o++;
    end
    sl_head[s] = 1; sl_free[s] = 1; sl_order[s] = o;
    r.st = bba_pkg::ST_OK;
    return r;
  endfunction

  // predict at queue time: the DUT processes items in order
  task automatic queue_req(bba_pkg::op_t op, logic [15:0] size, logic [31:0] addr);
    req_t q;
    rsp_t r;
    q.op = op; q.size = size; q.addr = addr;
    if (op == bba_pkg::OP_ALLOC) begin
      r = allocate_block(size);
      if (r.st == bba_pkg::ST_OK) begin
        live_addrs.push_back(r.addr);
        n_ok_alloc++;
      end
    end else begin
      r = release_block(addr);
      if (r.st == bba_pkg::ST_OK) n_ok_free++;
    end
    pending_reqs.push_back(q);
    expected_rsps.push_back(r);
  endtask

  task automatic rand_alloc();
    int k;
    logic [15:0] sz;
    k = $urandom_range(0, 19);
    if (k == 0) sz = 0;
    else if (k == 1) sz = 16'($urandom);
    else if (k < 12) sz = 16'($urandom_range(1, 120));
    else sz = 16'($urandom_range(1, (1 << MaxOrder) - HdrBytes + 2));
    queue_req(bba_pkg::OP_ALLOC, sz, $urandom);
  endtask

  task automatic rand_free();
    int k, j;
    logic [31:0] a;
    k = $urandom_range(0, 9);
    if (live_addrs.size() > 0 && k < 8) begin
      j = $urandom_range(0, live_addrs.size() - 1);
      a = live_addrs[j];
      live_addrs.delete(j);
    end else if (k == 8) begin
      a = $urandom;
    end else begin
      a = base_q + HdrBytes + ($urandom_range(0, NumSlots + 4) << MinOrder) + $urandom_range(0, 1);
    end
    queue_req(bba_pkg::OP_FREE, 16'($urandom), a);
  endtask

  // wait until the block has drained, then write one register
  task automatic write_reg(bba_pkg::reg_idx_t idx, logic [31:0] val);
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
    repeat (2 * NumSlots + 50) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bba_pkg::REG_POOL_BASE) begin
      base_q = val;
    end else begin
      pages_q = val[4:0];
      reset_pool();
      live_addrs.delete();
    end
  endtask

  task automatic run_phase(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 55 || live_addrs.size() == 0) rand_alloc();
      else rand_free();
    end
  endtask

  // driver
  int gap_in = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      n_sent++;
      void'(pending_reqs.pop_front());
      gap_in = $urandom_range(0, 3);
      if (gap_in == 0 && pending_reqs.size() > 0) begin
        operation <= pending_reqs[0].op;
        request_size <= pending_reqs[0].size;
        free_address <= pending_reqs[0].addr;
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (gap_in > 0) begin
        gap_in--;
      end else if (pending_reqs.size() > 0) begin
        in_valid <= 1'b1;
        operation <= pending_reqs[0].op;
        request_size <= pending_reqs[0].size;
        free_address <= pending_reqs[0].addr;
      end
    end
  end

  // monitor and receiver stall: hold stall for a drawn number of cycles per transfer
  int gap_out = 0;
  always @(posedge clk) begin
    cycles++;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_seen++;
        if (expected_rsps.size() == 0) begin
          $error("result with no expectation: addr %h status %0d", result_address, status);
          errors++;
        end else begin
          if (result_address !== expected_rsps[0].addr) begin
            $error("result_address exp %h got %h", expected_rsps[0].addr, result_address);
            errors++;
          end
          if (status !== expected_rsps[0].st) begin
            $error("status exp %0d got %0d", expected_rsps[0].st, status);
            errors++;
          end
          void'(expected_rsps.pop_front());
        end
        gap_out = $urandom_range(0, 3);
      end else if (gap_out > 0) begin
        gap_out--;
      end
      out_stall <= (gap_out > 0);
    end
    if (cycles > CycleCap) begin
      $display("FAIL buddy_block_allocator");
      $finish;
    end
  end

  initial begin
    base_q = 0;
    pages_q = bba_pkg::PagesReset;
    reset_pool();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes and special cases
    queue_req(bba_pkg::OP_ALLOC, 16'd0, 32'd0);
    queue_req(bba_pkg::OP_ALLOC, 16'd1, 32'd0);
    queue_req(bba_pkg::OP_ALLOC, 16'd8, 32'd0);
    queue_req(bba_pkg::OP_ALLOC, 16'd9, 32'd0);
    queue_req(bba_pkg::OP_ALLOC, 16'((1 << MaxOrder) - HdrBytes), 32'd0);
    queue_req(bba_pkg::OP_ALLOC, 16'((1 << MaxOrder) - HdrBytes + 1), 32'd0);
    queue_req(bba_pkg::OP_ALLOC, 16'hFFFF, 32'hFFFF_FFFF);
    queue_req(bba_pkg::OP_FREE, 16'hFFFF, 32'd0);
    queue_req(bba_pkg::OP_FREE, 16'd0, 32'hFFFF_FFFF);
    queue_req(bba_pkg::OP_FREE, 16'd0, HdrBytes + 1);
    queue_req(bba_pkg::OP_FREE, 16'd0, HdrBytes + (NumSlots << MinOrder));
    queue_req(bba_pkg::OP_FREE, 16'd0, HdrBytes + 32);
    queue_req(bba_pkg::OP_FREE, 16'd0, HdrBytes);
    queue_req(bba_pkg::OP_FREE, 16'd0, HdrBytes);
    live_addrs.delete();
    for (int n = 0; n < 8; n++) queue_req(bba_pkg::OP_ALLOC, 16'd2000, 32'd0);
    run_phase(400);
    // hold off until all results are back
    while (expected_rsps.size() != 0) @(posedge clk);
    run_phase(200);
    write_reg(bba_pkg::REG_PAGES_IN_USE, 32'd1);
    write_reg(bba_pkg::REG_POOL_BASE, 32'hFFFF_FF00);
    for (int n = 0; n < 6; n++) queue_req(bba_pkg::OP_ALLOC, 16'd40, 32'd0);
    run_phase(200);
    write_reg(bba_pkg::REG_PAGES_IN_USE, 32'd0);
    queue_req(bba_pkg::OP_ALLOC, 16'd1, 32'd0);
    queue_req(bba_pkg::OP_FREE, 16'd0, 32'hFFFF_FF18);
    write_reg(bba_pkg::REG_PAGES_IN_USE, 32'h1F);
    write_reg(bba_pkg::REG_POOL_BASE, $urandom);
    run_phase(300);
    write_reg(bba_pkg::REG_PAGES_IN_USE, 32'd3);
    write_reg(bba_pkg::REG_POOL_BASE, 32'd0);
    run_phase(300);
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
    repeat (2 * NumSlots + 50) @(posedge clk);
    $display("Sent %0d requests, checked %0d results (%0d allocs, %0d frees succeeded).",
             n_sent, n_seen, n_ok_alloc, n_ok_free);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("PASS buddy_block_allocator");
    end else begin
      $display("FAIL buddy_block_allocator");
    end
    $finish;
  end

endmodule
